FILE: rtl/uyc_pkg.sv
// ----------------------------------------------------------------------------
// uyc_pkg
// Shared types, constants and helpers for the UYVY to BGR converter.
// ----------------------------------------------------------------------------
package uyc_pkg;

   // Fraction bits of the color coefficients
   localparam int FRAC_SHIFT = 13;

   localparam int PIX_W   = 8;                  // one sample or channel
   localparam int COEF_W  = 16;                 // coefficient registers
   localparam int DELTA_W = PIX_W + 1;          // offset-removed sample
   localparam int PROD_W  = DELTA_W + COEF_W;   // sample times coefficient
   localparam int ACC_W   = PROD_W + 2;         // bias plus up to three products
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Y_OFFSET   = 3'd0,
      CSR_UV_ZERO    = 3'd1,
      CSR_Y_GAIN     = 3'd2,
      CSR_U_TO_BLUE  = 3'd3,
      CSR_U_TO_GREEN = 3'd4,
      CSR_V_TO_GREEN = 3'd5,
      CSR_V_TO_RED   = 3'd6,
      CSR_ROUND_BIAS = 3'd7
   } csr_index_type;

   // BT.601 at a 13-bit scale
   localparam logic [PIX_W-1:0]          RST_Y_OFFSET   = 8'd16;
   localparam logic [PIX_W-1:0]          RST_UV_ZERO    = 8'd128;
   localparam logic signed [COEF_W-1:0]  RST_Y_GAIN     = 16'sd9535;
   localparam logic signed [COEF_W-1:0]  RST_U_TO_BLUE  = 16'sd16531;
   localparam logic signed [COEF_W-1:0]  RST_U_TO_GREEN = -16'sd3203;
   localparam logic signed [COEF_W-1:0]  RST_V_TO_GREEN = -16'sd6660;
   localparam logic signed [COEF_W-1:0]  RST_V_TO_RED   = 16'sd13074;
   localparam logic [COEF_W-1:0]         RST_ROUND_BIAS = 16'd4096;

   typedef struct packed {
      logic [PIX_W-1:0]         y_offset;
      logic [PIX_W-1:0]         uv_zero;
      logic signed [COEF_W-1:0] y_gain;
      logic signed [COEF_W-1:0] u_to_blue;
      logic signed [COEF_W-1:0] u_to_green;
      logic signed [COEF_W-1:0] v_to_green;
      logic signed [COEF_W-1:0] v_to_red;
      logic [COEF_W-1:0]        round_bias;
   } cfg_type;

   // Macropixel, cb in the lowest bits
   typedef struct packed {
      logic [PIX_W-1:0] luma1;
      logic [PIX_W-1:0] cr;
      logic [PIX_W-1:0] luma0;
      logic [PIX_W-1:0] cb;
   } macropixel_type;

   // Two BGR pixels, blue0 in the lowest bits
   typedef struct packed {
      logic [PIX_W-1:0] red1;
      logic [PIX_W-1:0] green1;
      logic [PIX_W-1:0] blue1;
      logic [PIX_W-1:0] red0;
      logic [PIX_W-1:0] green0;
      logic [PIX_W-1:0] blue0;
   } bgr_pair_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] y0;
      logic signed [DELTA_W-1:0] y1;
      logic signed [DELTA_W-1:0] u;
      logic signed [DELTA_W-1:0] v;
   } delta_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] y0;
      logic signed [PROD_W-1:0] y1;
      logic signed [PROD_W-1:0] ub;
      logic signed [PROD_W-1:0] ug;
      logic signed [PROD_W-1:0] vg;
      logic signed [PROD_W-1:0] vr;
   } prod_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] base0;
      logic signed [ACC_W-1:0] base1;
      logic signed [ACC_W-1:0] blue;
      logic signed [ACC_W-1:0] green;
      logic signed [ACC_W-1:0] red;
   } part_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] b0;
      logic signed [ACC_W-1:0] g0;
      logic signed [ACC_W-1:0] r0;
      logic signed [ACC_W-1:0] b1;
      logic signed [ACC_W-1:0] g1;
      logic signed [ACC_W-1:0] r1;
   } acc_type;

   // Arithmetic shift down, then saturate to 0..255
   function automatic logic [PIX_W-1:0] shift_clamp(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      logic [PIX_W-1:0]        res;
      q = acc >>> FRAC_SHIFT;
      if (q[ACC_W-1]) begin
         res = '0;
      end else if (|q[ACC_W-2:PIX_W]) begin
         res = '1;
      end else begin
         res = q[PIX_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/uyvy422_to_bgr_converter.sv
// ----------------------------------------------------------------------------
// uyvy422_to_bgr_converter
// UYVY 4:2:2 macropixel to two BGR24 pixels, programmable coefficients.
// ----------------------------------------------------------------------------
// Each request carries one macropixel (Cb, Y0, Cr, Y1) and yields one response
// with two BGR pixels sharing that chroma. Throughput is one macropixel per
// clock when rsp_tready does not stall; an accepted request passes through
// the five register stages to the response side: offset removal, multiply,
// bias/pair add, channel sum, and shift/clamp into the output register.
// Every stage holds its own valid bit, so a stall at rsp_tready only stops
// stages that are full and bubbles are squeezed out. Coefficients reset to
// BT.601 (13 fraction bits) and may be rewritten through the csr port while
// no request is in flight.
// ----------------------------------------------------------------------------
module uyvy422_to_bgr_converter (
   input  logic                             clock,
   input  logic                             reset,
   // request: cb[7:0], luma0[15:8], cr[23:16], luma1[31:24]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   // response: blue0, green0, red0, blue1, green1, red1 (8 bits each, low up)
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [47:0]                      rsp_tdata,
   // register write port
   input  logic                             csr_we,
   input  logic [uyc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [uyc_pkg::COEF_W-1:0]       csr_wdata
);
   import uyc_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   macropixel_type req_pix;
   bgr_pair_type   rsp_pix;

   logic     prod_valid, prod_ready;
   prod_type prod_data;
   logic     acc_valid, acc_ready;
   acc_type  acc_data;

   // Register file: plain write, low bits kept for the 8-bit registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_Y_OFFSET:   cfg_in.y_offset   = csr_wdata[PIX_W-1:0];
            CSR_UV_ZERO:    cfg_in.uv_zero    = csr_wdata[PIX_W-1:0];
            CSR_Y_GAIN:     cfg_in.y_gain     = $signed(csr_wdata);
            CSR_U_TO_BLUE:  cfg_in.u_to_blue  = $signed(csr_wdata);
            CSR_U_TO_GREEN: cfg_in.u_to_green = $signed(csr_wdata);
            CSR_V_TO_GREEN: cfg_in.v_to_green = $signed(csr_wdata);
            CSR_V_TO_RED:   cfg_in.v_to_red   = $signed(csr_wdata);
            CSR_ROUND_BIAS: cfg_in.round_bias = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.y_offset   <= RST_Y_OFFSET;
         cfg_ff.uv_zero    <= RST_UV_ZERO;
         cfg_ff.y_gain     <= RST_Y_GAIN;
         cfg_ff.u_to_blue  <= RST_U_TO_BLUE;
         cfg_ff.u_to_green <= RST_U_TO_GREEN;
         cfg_ff.v_to_green <= RST_V_TO_GREEN;
         cfg_ff.v_to_red   <= RST_V_TO_RED;
         cfg_ff.round_bias <= RST_ROUND_BIAS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_pix = req_tdata;

   // stages 1-2: y/u/v deltas, then the six products
   uyc_product u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_pix),
      .cfg       (cfg_ff),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // stages 3-4: bias + luma, chroma green pair, then per-channel sums
   uyc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prod_valid),
      .in_ready   (prod_ready),
      .in_data    (prod_data),
      .round_bias (cfg_ff.round_bias),
      .out_valid  (acc_valid),
      .out_ready  (acc_ready),
      .out_data   (acc_data)
   );

   // stage 5: arithmetic shift, saturate, output register
   uyc_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_data   (acc_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_pix)
   );

   assign rsp_tdata = rsp_pix;

endmodule

FILE: rtl/uyc_product.sv
// ----------------------------------------------------------------------------
// uyc_product
// Offset removal stage followed by the six coefficient multipliers.
// ----------------------------------------------------------------------------
module uyc_product (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  uyc_pkg::macropixel_type in_data,
   input  uyc_pkg::cfg_type        cfg,
   output logic                    out_valid,
   input  logic                    out_ready,
   output uyc_pkg::prod_type       out_data
);
   import uyc_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   logic      s1_ready, s2_ready;
   delta_type s1_data_ff, s1_data_in;
   prod_type  s2_data_ff, s2_data_in;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

      s1_data_in.y0 = $signed({1'b0, in_data.luma0}) - $signed({1'b0, cfg.y_offset});
      s1_data_in.y1 = $signed({1'b0, in_data.luma1}) - $signed({1'b0, cfg.y_offset});
      s1_data_in.u  = $signed({1'b0, in_data.cb}) - $signed({1'b0, cfg.uv_zero});
      s1_data_in.v  = $signed({1'b0, in_data.cr}) - $signed({1'b0, cfg.uv_zero});

      s2_data_in.y0 = PROD_W'(s1_data_ff.y0) * PROD_W'(cfg.y_gain);
      s2_data_in.y1 = PROD_W'(s1_data_ff.y1) * PROD_W'(cfg.y_gain);
      s2_data_in.ub = PROD_W'(s1_data_ff.u) * PROD_W'(cfg.u_to_blue);
      s2_data_in.ug = PROD_W'(s1_data_ff.u) * PROD_W'(cfg.u_to_green);
      s2_data_in.vg = PROD_W'(s1_data_ff.v) * PROD_W'(cfg.v_to_green);
      s2_data_in.vr = PROD_W'(s1_data_ff.v) * PROD_W'(cfg.v_to_red);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_ready) begin
         s1_data_ff <= s1_data_in;
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

FILE: rtl/uyc_accum.sv
// ----------------------------------------------------------------------------
// uyc_accum
// Two adder stages: bias plus luma and the green chroma pair, then per-channel sums.
// ----------------------------------------------------------------------------
module uyc_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  uyc_pkg::prod_type             in_data,
   input  logic [uyc_pkg::COEF_W-1:0]    round_bias,
   output logic                          out_valid,
   input  logic                          out_ready,
   output uyc_pkg::acc_type              out_data
);
   import uyc_pkg::*;

   logic     s3_valid_ff, s3_valid_in;
   logic     s4_valid_ff, s4_valid_in;
   logic     s3_ready, s4_ready;
   part_type s3_data_ff, s3_data_in;
   acc_type  s4_data_ff, s4_data_in;
   logic signed [ACC_W-1:0] bias;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign bias     = ACC_W'($signed({1'b0, round_bias}));

   always_comb begin
      s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
      s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

      s3_data_in.base0 = bias + ACC_W'(in_data.y0);
      s3_data_in.base1 = bias + ACC_W'(in_data.y1);
      s3_data_in.blue  = ACC_W'(in_data.ub);
      s3_data_in.green = ACC_W'(in_data.ug) + ACC_W'(in_data.vg);
      s3_data_in.red   = ACC_W'(in_data.vr);

      s4_data_in.b0 = s3_data_ff.base0 + s3_data_ff.blue;
      s4_data_in.g0 = s3_data_ff.base0 + s3_data_ff.green;
      s4_data_in.r0 = s3_data_ff.base0 + s3_data_ff.red;
      s4_data_in.b1 = s3_data_ff.base1 + s3_data_ff.blue;
      s4_data_in.g1 = s3_data_ff.base1 + s3_data_ff.green;
      s4_data_in.r1 = s3_data_ff.base1 + s3_data_ff.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
      if (s4_ready) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign in_ready  = s3_ready;
   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

FILE: rtl/uyc_clamp.sv
// ----------------------------------------------------------------------------
// uyc_clamp
// Shift and saturate each channel into the output register.
// ----------------------------------------------------------------------------
module uyc_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  uyc_pkg::acc_type      in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output uyc_pkg::bgr_pair_type out_data
);
   import uyc_pkg::*;

   logic         s5_valid_ff, s5_valid_in;
   logic         s5_ready;
   bgr_pair_type s5_data_ff, s5_data_in;

   assign s5_ready = !s5_valid_ff || out_ready;

   always_comb begin
      s5_valid_in       = s5_ready ? in_valid : s5_valid_ff;
      s5_data_in.blue0  = shift_clamp(in_data.b0);
      s5_data_in.green0 = shift_clamp(in_data.g0);
      s5_data_in.red0   = shift_clamp(in_data.r0);
      s5_data_in.blue1  = shift_clamp(in_data.b1);
      s5_data_in.green1 = shift_clamp(in_data.g1);
      s5_data_in.red1   = shift_clamp(in_data.r1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
      if (s5_ready) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign in_ready  = s5_ready;
   assign out_valid = s5_valid_ff;
   assign out_data  = s5_data_ff;

endmodule

FILE: rtl/uyc_checker.sv
// ----------------------------------------------------------------------------
// uyc_checker
// Port-level assertions for the UYVY to BGR converter, bound to the top.
// ----------------------------------------------------------------------------
module uyc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // and keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // output slot free means the whole pipeline can move: request side open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled with free output");

endmodule

bind uyvy422_to_bgr_converter uyc_checker u_uyc_checker (.*);
